@@ rtl/twg_pkg.sv @@
// ----------------------------------------------------------------------------
// twg_pkg: shared types and constants for the test waveform generator
// Register indexes, waveform modes, sine polynomial coefficients and the
// microcode program of the sequencer.
// ----------------------------------------------------------------------------
package twg_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int MODE_WIDTH      = 2;
  localparam int PERIOD_WIDTH    = 16;
  localparam int AMP_WIDTH       = 16;
  localparam int COUNT_WIDTH     = 24;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 24;
  localparam int UPC_WIDTH       = 5;
  localparam int POLY_WIDTH      = 31;
  localparam int PROD_WIDTH      = 2 * POLY_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE      = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_AMPLITUDE = 2'd2,
    REG_COUNT     = 2'd3
  } cfg_reg_t;

  localparam logic [MODE_WIDTH-1:0] MODE_SINE = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_SAW  = 2'd1;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd64;
  localparam logic [AMP_WIDTH-1:0]    AMP_RESET    = 16'd32768;
  localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET  = 24'd1024;

  localparam logic [POLY_WIDTH-1:0] COEF_A = 31'd1686629713;
  localparam logic [POLY_WIDTH-1:0] COEF_B = 31'd693598670;
  localparam logic [POLY_WIDTH-1:0] COEF_C = 31'd85569305;
  localparam logic [POLY_WIDTH-1:0] COEF_D = 31'd5026989;
  localparam logic [POLY_WIDTH-1:0] COEF_E = 31'd172272;

  typedef enum logic [4:0] {
    OP_NOP      = 5'd0,
    OP_DIV_LDS  = 5'd1,
    OP_DIV_LDP  = 5'd2,
    OP_DIV_STEP = 5'd3,
    OP_ANGLE    = 5'd4,
    OP_MUL_XX   = 5'd5,
    OP_X2       = 5'd6,
    OP_MUL_X2S  = 5'd7,
    OP_SUB_D    = 5'd8,
    OP_SUB_C    = 5'd9,
    OP_SUB_B    = 5'd10,
    OP_SUB_A    = 5'd11,
    OP_MUL_XS   = 5'd12,
    OP_ROUND    = 5'd13,
    OP_MUL_AMP  = 5'd14,
    OP_SINE_OUT = 5'd15,
    OP_MUL_PM   = 5'd16,
    OP_SAW_OUT  = 5'd17,
    OP_ZERO_OUT = 5'd18
  } uop_t;

  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_SAW      = 3'd1,
    COND_OFF      = 3'd2,
    COND_DIV_BUSY = 3'd3
  } cond_t;

  typedef struct packed {
    uop_t                 op;
    cond_t                cond;
    logic [UPC_WIDTH-1:0] target;
  } ucode_t;

  localparam logic [UPC_WIDTH-1:0] L_SINE_DIV = 5'd2;
  localparam logic [UPC_WIDTH-1:0] L_SAW      = 5'd18;
  localparam logic [UPC_WIDTH-1:0] L_SAW_DIV  = 5'd20;
  localparam logic [UPC_WIDTH-1:0] L_ZERO     = 5'd22;

  function automatic ucode_t ucode_rom(input logic [UPC_WIDTH-1:0] addr);
    ucode_t w;
    w = '{op: OP_ZERO_OUT, cond: COND_NONE, target: L_ZERO};
    case (addr)
      5'd0:  w = '{op: OP_DIV_LDS,  cond: COND_SAW,      target: L_SAW};
      5'd1:  w = '{op: OP_NOP,      cond: COND_OFF,      target: L_ZERO};
      5'd2:  w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: L_SINE_DIV};
      5'd3:  w = '{op: OP_ANGLE,    cond: COND_NONE,     target: L_ZERO};
      5'd4:  w = '{op: OP_MUL_XX,   cond: COND_NONE,     target: L_ZERO};
      5'd5:  w = '{op: OP_X2,       cond: COND_NONE,     target: L_ZERO};
      5'd6:  w = '{op: OP_MUL_X2S,  cond: COND_NONE,     target: L_ZERO};
      5'd7:  w = '{op: OP_SUB_D,    cond: COND_NONE,     target: L_ZERO};
      5'd8:  w = '{op: OP_MUL_X2S,  cond: COND_NONE,     target: L_ZERO};
      5'd9:  w = '{op: OP_SUB_C,    cond: COND_NONE,     target: L_ZERO};
      5'd10: w = '{op: OP_MUL_X2S,  cond: COND_NONE,     target: L_ZERO};
      5'd11: w = '{op: OP_SUB_B,    cond: COND_NONE,     target: L_ZERO};
      5'd12: w = '{op: OP_MUL_X2S,  cond: COND_NONE,     target: L_ZERO};
      5'd13: w = '{op: OP_SUB_A,    cond: COND_NONE,     target: L_ZERO};
      5'd14: w = '{op: OP_MUL_XS,   cond: COND_NONE,     target: L_ZERO};
      5'd15: w = '{op: OP_ROUND,    cond: COND_NONE,     target: L_ZERO};
      5'd16: w = '{op: OP_MUL_AMP,  cond: COND_NONE,     target: L_ZERO};
      5'd17: w = '{op: OP_SINE_OUT, cond: COND_NONE,     target: L_ZERO};
      5'd18: w = '{op: OP_MUL_PM,   cond: COND_NONE,     target: L_ZERO};
      5'd19: w = '{op: OP_DIV_LDP,  cond: COND_NONE,     target: L_ZERO};
      5'd20: w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: L_SAW_DIV};
      5'd21: w = '{op: OP_SAW_OUT,  cond: COND_NONE,     target: L_ZERO};
      5'd22: w = '{op: OP_ZERO_OUT, cond: COND_NONE,     target: L_ZERO};
      default: w = '{op: OP_ZERO_OUT, cond: COND_NONE, target: L_ZERO};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/twg_in_if.sv @@
// ----------------------------------------------------------------------------
// twg_in_if: input item channel of the test waveform generator
// Carries the restart flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface twg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/twg_out_if.sv @@
// ----------------------------------------------------------------------------
// twg_out_if: result item channel of the test waveform generator
// Carries one signed sample and the last flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface twg_out_if
  import twg_pkg::*;
;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

@@ rtl/twg_cfg_if.sv @@
// ----------------------------------------------------------------------------
// twg_cfg_if: configuration write channel of the test waveform generator
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface twg_cfg_if
  import twg_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/test_waveform_generator_unit.sv @@
// ----------------------------------------------------------------------------
// test_waveform_generator_unit: sine and sawtooth test sample generator
// Each input item (restart flag) yields one result item: a signed 16-bit
// sample and a flag on the final sample of the buffer. Registers are written
// through the configuration channel (mode, period, amplitude, sample count);
// the user is to write them only while the block is idle, which the block
// does not enforce; that channel is ready whenever reset is released. Work
// is sequenced by a microcode program driving one divider step unit and one
// 31x31 multiplier. The 16-step restoring division by the period sets the
// pace: a sawtooth item runs a multiply, the division and its output step,
// a sine item the division plus fifteen angle, polynomial and scaling steps,
// other modes go straight to a zero output. One item is worked on at a time;
// the next item can be accepted in the same cycle as the previous result
// reaches the output register, which holds it until the receiver takes it;
// a stalled receiver holds the program at its final step. Reset clears the
// sample index, period position and registers to reset values, holds both
// ready signals low, and leaves the block idle with no result pending.
// ----------------------------------------------------------------------------
module test_waveform_generator_unit
  import twg_pkg::*;
#(
  parameter int ANGLE_BITS = 12
) (
  input logic      clk,
  input logic      rst_n,
  twg_in_if.sink   in_ch,
  twg_out_if.source out_ch,
  twg_cfg_if.sink  cfg_ch
);

  localparam int QBITS = ANGLE_BITS - 2;
  localparam int XSHIFT = 30 - QBITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [UPC_WIDTH-1:0]       upc_r, upc_nxt;
  logic [3:0]                 div_cnt_r, div_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [MODE_WIDTH-1:0]      mode_r, mode_nxt;
  logic [PERIOD_WIDTH-1:0]    period_r, period_nxt;
  logic [AMP_WIDTH-1:0]       amplitude_r, amplitude_nxt;
  logic [COUNT_WIDTH-1:0]     count_r, count_nxt;
  logic [COUNT_WIDTH-1:0]     index_r, index_nxt;
  logic [PERIOD_WIDTH-1:0]    pos_r, pos_nxt;

  logic [PERIOD_WIDTH-1:0]    p_r, p_nxt;
  logic                       last_r, last_nxt;
  logic                       zero_r, zero_nxt;
  logic [15:0]                rem_r, rem_nxt;
  logic [31:0]                n_r, n_nxt;
  logic [POLY_WIDTH-1:0]      x_r, x_nxt;
  logic [POLY_WIDTH-1:0]      x2_r, x2_nxt;
  logic [POLY_WIDTH-1:0]      s_r, s_nxt;
  logic [PROD_WIDTH-1:0]      prod_r, prod_nxt;
  logic [14:0]                mag_r, mag_nxt;
  logic                       quad_neg_r, quad_neg_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic                       olast_r, olast_nxt;

  ucode_t                     uw;
  logic                       in_acc;
  logic                       out_free;
  logic                       jump;
  logic [PERIOD_WIDTH-1:0]    per_eff;
  logic [COUNT_WIDTH:0]       cnt_eff;
  logic [COUNT_WIDTH:0]       index_inc;
  logic [COUNT_WIDTH-1:0]     index_cur;
  logic [PERIOD_WIDTH-1:0]    pos_cur;
  logic [PERIOD_WIDTH-1:0]    p_cur;
  logic [PERIOD_WIDTH:0]      p_inc;
  logic                       last_cur;
  logic [16:0]                div_trial;
  logic                       div_ge;
  logic [31:0]                n_sine;
  logic [QBITS-1:0]           ang_r;
  logic [QBITS:0]             ang_x;
  logic [POLY_WIDTH-1:0]      prod_hi;
  logic [31:0]                rnd;
  logic [16:0]                rnd_sh;
  logic [14:0]                amp_half;
  logic                       amp_neg;
  logic [14:0]                amag;
  logic [AMP_WIDTH-1:0]       saw_m;
  logic [POLY_WIDTH-1:0]      mul_a, mul_b;
  logic [15:0]                sine_mag;
  logic [15:0]                sine_val;

  assign uw        = ucode_rom(upc_r);
  assign in_ch.ready  = rst_n && (state_r == ST_IDLE);
  assign cfg_ch.ready = rst_n;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;
  assign out_ch.last   = olast_r;

  assign per_eff   = (period_r == '0) ? 16'd1 : period_r;
  assign cnt_eff   = (count_r == '0) ? {1'b1, {COUNT_WIDTH{1'b0}}} : {1'b0, count_r};
  assign index_cur = in_ch.restart ? '0 : index_r;
  assign pos_cur   = in_ch.restart ? '0 : pos_r;
  assign p_cur     = (pos_cur < per_eff) ? pos_cur : '0;
  assign p_inc     = {1'b0, p_cur} + 17'd1;
  assign index_inc = {1'b0, index_cur} + 25'd1;
  assign last_cur  = (index_inc >= cnt_eff);

  assign div_trial = {rem_r, n_r[31]};
  assign div_ge    = (div_trial >= {1'b0, per_eff});
  assign n_sine    = {16'b0, p_r} << ANGLE_BITS;

  assign ang_r  = n_r[QBITS-1:0];
  assign ang_x  = n_r[QBITS] ? ({1'b1, {QBITS{1'b0}}} - {1'b0, ang_r}) : {1'b0, ang_r};

  assign prod_hi = prod_r[60:30];
  assign rnd     = {1'b0, prod_hi} + 32'd16384;
  assign rnd_sh  = rnd[31:15];

  assign amp_half = amplitude_r[AMP_WIDTH-1:1];
  assign amp_neg  = (amp_half == '0);
  assign amag     = amp_neg ? 15'd1 : (amp_half - 15'd1);
  assign saw_m    = (amplitude_r == '0) ? '0 : (amplitude_r - 16'd1);

  assign sine_mag = {1'b0, prod_r[29:15]};
  assign sine_val = (quad_neg_r ^ amp_neg) ? (16'd0 - sine_mag) : sine_mag;

  always_comb begin
    mul_a = x2_r;
    mul_b = s_r;
    case (uw.op)
      OP_MUL_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      OP_MUL_XS: begin
        mul_a = x_r;
        mul_b = s_r;
      end
      OP_MUL_AMP: begin
        mul_a = {16'b0, mag_r};
        mul_b = {16'b0, amag};
      end
      OP_MUL_PM: begin
        mul_a = {15'b0, p_r};
        mul_b = {15'b0, saw_m};
      end
      default: begin
        mul_a = x2_r;
        mul_b = s_r;
      end
    endcase
  end

  always_comb begin
    jump = 1'b0;
    case (uw.cond)
      COND_NONE:     jump = 1'b0;
      COND_SAW:      jump = (mode_r == MODE_SAW);
      COND_OFF:      jump = (mode_r != MODE_SINE) && (mode_r != MODE_SAW);
      COND_DIV_BUSY: jump = (div_cnt_r != 4'd15);
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    upc_nxt       = upc_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mode_nxt      = mode_r;
    period_nxt    = period_r;
    amplitude_nxt = amplitude_r;
    count_nxt     = count_r;
    index_nxt     = index_r;
    pos_nxt       = pos_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    zero_nxt      = zero_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    s_nxt         = s_r;
    prod_nxt      = prod_r;
    mag_nxt       = mag_r;
    quad_neg_nxt  = quad_neg_r;
    sample_nxt    = sample_r;
    olast_nxt     = olast_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MODE:      mode_nxt      = cfg_ch.data[MODE_WIDTH-1:0];
        REG_PERIOD:    period_nxt    = cfg_ch.data[PERIOD_WIDTH-1:0];
        REG_AMPLITUDE: amplitude_nxt = cfg_ch.data[AMP_WIDTH-1:0];
        REG_COUNT:     count_nxt     = cfg_ch.data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          p_nxt     = p_cur;
          last_nxt  = last_cur;
          zero_nxt  = last_cur && count_r[0];
          index_nxt = last_cur ? '0 : index_inc[COUNT_WIDTH-1:0];
          pos_nxt   = (last_cur || (p_inc >= {1'b0, per_eff})) ? '0 : p_inc[PERIOD_WIDTH-1:0];
          upc_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        upc_nxt = jump ? uw.target : (upc_r + 5'd1);
        case (uw.op)
          OP_NOP: ;
          OP_DIV_LDS: begin
            rem_nxt     = n_sine[31:16];
            n_nxt       = {n_sine[15:0], 16'b0};
            div_cnt_nxt = '0;
          end
          OP_DIV_LDP: begin
            rem_nxt     = prod_r[31:16];
            n_nxt       = {prod_r[15:0], 16'b0};
            div_cnt_nxt = '0;
          end
          OP_DIV_STEP: begin
            rem_nxt     = div_ge ? (div_trial[15:0] - per_eff) : div_trial[15:0];
            n_nxt       = {n_r[30:0], div_ge};
            div_cnt_nxt = div_cnt_r + 4'd1;
          end
          OP_ANGLE: begin
            x_nxt        = {ang_x, {XSHIFT{1'b0}}};
            quad_neg_nxt = n_r[QBITS+1];
            s_nxt        = COEF_E;
          end
          OP_MUL_XX, OP_MUL_X2S, OP_MUL_XS, OP_MUL_AMP, OP_MUL_PM: begin
            prod_nxt = {{POLY_WIDTH{1'b0}}, mul_a} * {{POLY_WIDTH{1'b0}}, mul_b};
          end
          OP_X2:    x2_nxt = prod_hi;
          OP_SUB_D: s_nxt  = COEF_D - prod_hi;
          OP_SUB_C: s_nxt  = COEF_C - prod_hi;
          OP_SUB_B: s_nxt  = COEF_B - prod_hi;
          OP_SUB_A: s_nxt  = COEF_A - prod_hi;
          OP_ROUND: mag_nxt = (rnd_sh > 17'd32767) ? 15'h7fff : rnd_sh[14:0];
          OP_SINE_OUT, OP_SAW_OUT, OP_ZERO_OUT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              olast_nxt     = last_r;
              state_nxt     = ST_IDLE;
              if (zero_r || (uw.op == OP_ZERO_OUT)) begin
                sample_nxt = '0;
              end else if (uw.op == OP_SAW_OUT) begin
                sample_nxt = signed'({n_r[14:0], 1'b0});
              end else begin
                sample_nxt = signed'(sine_val);
              end
            end else begin
              upc_nxt = upc_r;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_SINE;
      period_r    <= PERIOD_RESET;
      amplitude_r <= AMP_RESET;
      count_r     <= COUNT_RESET;
      index_r     <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      upc_r       <= upc_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      period_r    <= period_nxt;
      amplitude_r <= amplitude_nxt;
      count_r     <= count_nxt;
      index_r     <= index_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    zero_r     <= zero_nxt;
    rem_r      <= rem_nxt;
    n_r        <= n_nxt;
    x_r        <= x_nxt;
    x2_r       <= x2_nxt;
    s_r        <= s_nxt;
    prod_r     <= prod_nxt;
    mag_r      <= mag_nxt;
    quad_neg_r <= quad_neg_nxt;
    sample_r   <= sample_nxt;
    olast_r    <= olast_nxt;
  end

endmodule
